[rtl/core/circular_heading_utility_unit_defines.svh]
// assertion macros shared by the heading utility modules
`ifndef CIRCULAR_HEADING_UTILITY_UNIT_DEFINES_SVH
`define CIRCULAR_HEADING_UTILITY_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CHU_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define CHU_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/chu_pkg.sv]
package chu_pkg;

   localparam int IDX_W      = 10;
   localparam int ANG_W      = 13;
   localparam int DIST_W     = 12;
   localparam int UTIL_W     = 16;
   localparam int PROD_W     = UTIL_W + DIST_W;
   localparam int QUO_W      = UTIL_W;
   localparam int DIV_STEPS  = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int NUM_POINTS  = 360;
   localparam int DOMAIN_STEP = 16;
   localparam int DOMAIN_LOW  = 0;

   localparam logic [ANG_W-1:0]  FULL_ANG  = 13'd5760;
   localparam logic [DIST_W-1:0] HALF_DIST = 12'd2880;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SUMMIT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PORT_DELTA = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STBD_DELTA = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PORT_BRK   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STBD_BRK   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PORT_MIN   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_STBD_MIN   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_PEAK       = 3'd7;

   typedef struct packed {
      logic [ANG_W-1:0]  summit;
      logic [DIST_W-1:0] port_delta;
      logic [DIST_W-1:0] stbd_delta;
      logic [UTIL_W-1:0] port_brk;
      logic [UTIL_W-1:0] stbd_brk;
      logic [UTIL_W-1:0] port_min;
      logic [UTIL_W-1:0] stbd_min;
      logic [UTIL_W-1:0] peak;
   } cfg_type;

   typedef struct packed {
      logic              zero;
      logic              on_starboard;
      logic [DIST_W-1:0] offset;
      logic [DIST_W-1:0] delta;
      logic [UTIL_W-1:0] brk;
      logic [UTIL_W-1:0] lo;
      logic [UTIL_W-1:0] top;
   } side_type;

   typedef struct packed {
      logic              on_starboard;
      logic              bypass;
      logic              neg;
      logic [UTIL_W-1:0] base;
      logic [UTIL_W-1:0] byp_val;
   } ctl_type;

endpackage

[rtl/core/circular_heading_utility_unit.sv]
// circular heading utility unit
// req channel: one heading index per beat (req_valid / req_stall); each beat
// gives exactly one rsp beat with the utility (unsigned Q8.8) and the side
// flag, in order of acceptance.
// csr channel: register index and data, written when csr_valid is high;
// csr_ready is always high. write registers only while the block is idle.
// an accepted index passes four front stages (angle map, side select,
// operand prep, multiply), eight radix-2 divider stages at two quotient
// bits each, and the output register, from which rsp_valid is driven.
// throughput: one index per cycle with no stall.
// a stalled rsp holds its beat; bubbles in the pipeline still close up, so
// req_stall rises only once every stage holds an item.
// reset clears the pipeline valids and loads the register defaults:
// summit 0, deltas 0, break utilities 12800, minimums 0, peak 25600.
module circular_heading_utility_unit #(
   parameter int NumPoints  = chu_pkg::NUM_POINTS,
   parameter int DomainStep = chu_pkg::DOMAIN_STEP,
   parameter int DomainLow  = chu_pkg::DOMAIN_LOW
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [chu_pkg::IDX_W-1:0]        req_heading_index,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [chu_pkg::UTIL_W-1:0]       rsp_utility,
   output logic                             rsp_on_starboard,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [chu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [chu_pkg::CSR_DATA_W-1:0]   csr_data
);

   chu_pkg::cfg_type                cfg_ff;
   chu_pkg::cfg_type                cfg_in;

   logic                            front_ready;
   logic                            front_valid;
   chu_pkg::side_type               side;
   logic                            prep_ready;
   logic                            prep_valid;
   logic [chu_pkg::PROD_W-1:0]      num;
   logic [chu_pkg::DIST_W-1:0]      den;
   chu_pkg::ctl_type                prep_ctl;
   logic                            div_ready;
   logic                            div_valid;
   logic [chu_pkg::QUO_W-1:0]       quo;
   chu_pkg::ctl_type                div_ctl;
   logic                            out_in_ready;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            chu_pkg::REG_SUMMIT:     cfg_in.summit     = csr_data[chu_pkg::ANG_W-1:0];
            chu_pkg::REG_PORT_DELTA: cfg_in.port_delta = csr_data[chu_pkg::DIST_W-1:0];
            chu_pkg::REG_STBD_DELTA: cfg_in.stbd_delta = csr_data[chu_pkg::DIST_W-1:0];
            chu_pkg::REG_PORT_BRK:   cfg_in.port_brk   = csr_data;
            chu_pkg::REG_STBD_BRK:   cfg_in.stbd_brk   = csr_data;
            chu_pkg::REG_PORT_MIN:   cfg_in.port_min   = csr_data;
            chu_pkg::REG_STBD_MIN:   cfg_in.stbd_min   = csr_data;
            chu_pkg::REG_PEAK:       cfg_in.peak       = csr_data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.summit     <= '0;
         cfg_ff.port_delta <= '0;
         cfg_ff.stbd_delta <= '0;
         cfg_ff.port_brk   <= 16'd12800;
         cfg_ff.stbd_brk   <= 16'd12800;
         cfg_ff.port_min   <= '0;
         cfg_ff.stbd_min   <= '0;
         cfg_ff.peak       <= 16'd25600;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   chu_front #(
      .NumPoints  (NumPoints),
      .DomainStep (DomainStep),
      .DomainLow  (DomainLow)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (front_ready),
      .heading_index (req_heading_index),
      .cfg           (cfg_ff),
      .out_valid     (front_valid),
      .out_ready     (prep_ready),
      .side          (side)
   );

   chu_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (prep_ready),
      .side      (side),
      .out_valid (prep_valid),
      .out_ready (div_ready),
      .num       (num),
      .den       (den),
      .ctl       (prep_ctl)
   );

   chu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (div_ready),
      .num       (num),
      .den       (den),
      .ctl       (prep_ctl),
      .out_valid (div_valid),
      .out_ready (out_in_ready),
      .quo       (quo),
      .out_ctl   (div_ctl)
   );

   chu_out u_out (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (div_valid),
      .in_ready     (out_in_ready),
      .quo          (quo),
      .ctl          (div_ctl),
      .out_valid    (rsp_valid),
      .out_ready    (!rsp_stall),
      .utility      (rsp_utility),
      .on_starboard (rsp_on_starboard)
   );

   assign req_stall = !front_ready;

endmodule

[rtl/core/chu_front.sv]
module chu_front #(
   parameter int NumPoints  = chu_pkg::NUM_POINTS,
   parameter int DomainStep = chu_pkg::DOMAIN_STEP,
   parameter int DomainLow  = chu_pkg::DOMAIN_LOW
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [chu_pkg::IDX_W-1:0]    heading_index,
   input  chu_pkg::cfg_type             cfg,
   output logic                         out_valid,
   input  logic                         out_ready,
   output chu_pkg::side_type            side
);

   localparam int AngRaw = $clog2(1023 * DomainStep + DomainLow + 1);
   localparam int AngW   = (AngRaw > chu_pkg::ANG_W) ? AngRaw : chu_pkg::ANG_W;

   logic [AngW-1:0]           ang_full;
   logic                      zero_in;
   logic                      v1_ff;
   logic                      zero1_ff;
   logic [chu_pkg::ANG_W-1:0] ang1_ff;
   logic                      ld1;
   logic                      ld2;

   logic [chu_pkg::ANG_W-1:0] sum;
   logic [chu_pkg::ANG_W:0]   wrap;
   logic                      left;
   logic [chu_pkg::ANG_W:0]   diff14;
   logic [chu_pkg::ANG_W:0]   dist14;
   logic [chu_pkg::DIST_W-1:0] delta_raw;
   chu_pkg::side_type         side_in;
   logic                      v2_ff;
   chu_pkg::side_type         side_ff;

   assign ld2      = !v2_ff || out_ready;
   assign ld1      = !v1_ff || ld2;
   assign in_ready = ld1;

   // index to angle
   assign ang_full = AngW'(heading_index) * AngW'(DomainStep) + AngW'(DomainLow);
   assign zero_in  = ({1'b0, heading_index} >= (chu_pkg::IDX_W + 1)'(NumPoints))
                     || (ang_full >= AngW'(chu_pkg::FULL_ANG));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (ld1) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         zero1_ff <= zero_in;
         ang1_ff  <= ang_full[chu_pkg::ANG_W-1:0];
      end
   end

   // side choice and distance from summit
   always_comb begin
      sum    = (cfg.summit >= chu_pkg::FULL_ANG) ? cfg.summit - chu_pkg::FULL_ANG
                                                 : cfg.summit;
      wrap   = {1'b0, sum} + {1'b0, chu_pkg::FULL_ANG} - {1'b0, ang1_ff};
      if (sum < {1'b0, chu_pkg::HALF_DIST}) begin
         left = (ang1_ff < sum) || (wrap < {2'b00, chu_pkg::HALF_DIST});
      end else begin
         left = (sum > ang1_ff) && ((sum - ang1_ff) < {1'b0, chu_pkg::HALF_DIST});
      end
      diff14 = left ? ({1'b0, sum} - {1'b0, ang1_ff})
                    : ({1'b0, ang1_ff} - {1'b0, sum});
      dist14 = diff14[chu_pkg::ANG_W] ? diff14 + {1'b0, chu_pkg::FULL_ANG} : diff14;
      delta_raw = left ? cfg.port_delta : cfg.stbd_delta;

      side_in.zero         = zero1_ff;
      side_in.on_starboard = !left && !zero1_ff;
      side_in.offset       = dist14[chu_pkg::DIST_W-1:0];
      side_in.delta        = (delta_raw > chu_pkg::HALF_DIST) ? chu_pkg::HALF_DIST
                                                              : delta_raw;
      side_in.brk          = left ? cfg.port_brk : cfg.stbd_brk;
      side_in.lo           = left ? cfg.port_min : cfg.stbd_min;
      side_in.top          = cfg.peak;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (ld2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld2) begin
         side_ff <= side_in;
      end
   end

   assign out_valid = v2_ff;
   assign side      = side_ff;

`include "circular_heading_utility_unit_defines.svh"

   `CHU_ASSERT_IMP(a_dist_half, v2_ff && !side_ff.zero, side_ff.offset <= chu_pkg::HALF_DIST, "distance beyond half circle")
   `CHU_ASSERT_NXT(a_s1_hold, v1_ff && !ld1, v1_ff && $stable(ang1_ff), "held stage lost its item")

endmodule

[rtl/core/chu_prep.sv]
module chu_prep (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  chu_pkg::side_type            side,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [chu_pkg::PROD_W-1:0]   num,
   output logic [chu_pkg::DIST_W-1:0]   den,
   output chu_pkg::ctl_type             ctl
);

   logic                        at_break;
   logic                        first;
   logic [chu_pkg::DIST_W-1:0]  run;
   logic [chu_pkg::UTIL_W-1:0]  base;
   logic [chu_pkg::UTIL_W-1:0]  endv;
   logic [chu_pkg::UTIL_W:0]    diff;
   logic [chu_pkg::UTIL_W:0]    mag_full;
   logic [chu_pkg::UTIL_W-1:0]  mag_in;
   logic [chu_pkg::DIST_W-1:0]  factor_in;
   logic [chu_pkg::DIST_W-1:0]  den_in;
   chu_pkg::ctl_type            ctl_in;

   logic                        v3_ff;
   logic [chu_pkg::UTIL_W-1:0]  mag3_ff;
   logic [chu_pkg::DIST_W-1:0]  factor3_ff;
   logic [chu_pkg::DIST_W-1:0]  den3_ff;
   chu_pkg::ctl_type            ctl3_ff;
   logic                        v4_ff;
   logic [chu_pkg::PROD_W-1:0]  prod4_ff;
   logic [chu_pkg::DIST_W-1:0]  den4_ff;
   chu_pkg::ctl_type            ctl4_ff;
   logic                        ld3;
   logic                        ld4;

   assign ld4      = !v4_ff || out_ready;
   assign ld3      = !v3_ff || ld4;
   assign in_ready = ld3;

   // segment choice and operands
   always_comb begin
      at_break  = side.offset == side.delta;
      first     = side.offset < side.delta;
      run       = chu_pkg::HALF_DIST - side.delta;
      base      = first ? side.top : side.brk;
      endv      = first ? side.brk : side.lo;
      diff      = {1'b0, base} - {1'b0, endv};
      mag_full  = diff[chu_pkg::UTIL_W] ? ((chu_pkg::UTIL_W + 1)'(0) - diff) : diff;
      mag_in    = mag_full[chu_pkg::UTIL_W-1:0];
      factor_in = first ? side.offset : side.offset - side.delta;
      den_in    = first ? side.delta : run;

      ctl_in.on_starboard = side.on_starboard;
      ctl_in.neg          = diff[chu_pkg::UTIL_W];
      ctl_in.base         = base;
      ctl_in.bypass       = side.zero || at_break || (!first && (run == '0));
      ctl_in.byp_val      = (at_break && !side.zero) ? side.brk : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (ld3) begin
            v3_ff <= in_valid;
         end
         if (ld4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld3) begin
         mag3_ff    <= mag_in;
         factor3_ff <= factor_in;
         den3_ff    <= den_in;
         ctl3_ff    <= ctl_in;
      end
      if (ld4) begin
         prod4_ff <= mag3_ff * factor3_ff;
         den4_ff  <= den3_ff;
         ctl4_ff  <= ctl3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign num       = prod4_ff;
   assign den       = den4_ff;
   assign ctl       = ctl4_ff;

endmodule

[rtl/core/chu_div.sv]
module chu_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [chu_pkg::PROD_W-1:0]   num,
   input  logic [chu_pkg::DIST_W-1:0]   den,
   input  chu_pkg::ctl_type             ctl,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [chu_pkg::QUO_W-1:0]    quo,
   output chu_pkg::ctl_type             out_ctl
);

   localparam int NStg = chu_pkg::QUO_W / chu_pkg::DIV_STEPS;

   logic                        v_ff   [NStg];
   logic [chu_pkg::PROD_W-1:0]  rem_ff [NStg];
   logic [chu_pkg::QUO_W-1:0]   quo_ff [NStg];
   logic [chu_pkg::DIST_W-1:0]  den_ff [NStg];
   chu_pkg::ctl_type            ctl_ff [NStg];
   logic                        ld     [NStg];

   for (genvar g = 0; g < NStg; g++) begin : g_stg
      logic                        v_src;
      logic [chu_pkg::PROD_W-1:0]  rem_src;
      logic [chu_pkg::QUO_W-1:0]   quo_src;
      logic [chu_pkg::DIST_W-1:0]  den_src;
      chu_pkg::ctl_type            ctl_src;
      logic [chu_pkg::PROD_W-1:0]  rem_in;
      logic [chu_pkg::QUO_W-1:0]   quo_in;

      if (g == 0) begin : g_head
         assign v_src   = in_valid;
         assign rem_src = num;
         assign quo_src = '0;
         assign den_src = den;
         assign ctl_src = ctl;
      end else begin : g_body
         assign v_src   = v_ff[g-1];
         assign rem_src = rem_ff[g-1];
         assign quo_src = quo_ff[g-1];
         assign den_src = den_ff[g-1];
         assign ctl_src = ctl_ff[g-1];
      end

      if (g == NStg - 1) begin : g_last
         assign ld[g] = !v_ff[g] || out_ready;
      end else begin : g_mid
         assign ld[g] = !v_ff[g] || ld[g+1];
      end

      // restoring steps, one quotient bit each
      always_comb begin
         logic [chu_pkg::PROD_W-1:0] trial;
         rem_in = rem_src;
         quo_in = quo_src;
         for (int s = 0; s < chu_pkg::DIV_STEPS; s++) begin
            trial = chu_pkg::PROD_W'(den_src)
                    << (chu_pkg::QUO_W - 1 - g * chu_pkg::DIV_STEPS - s);
            if (rem_in >= trial) begin
               rem_in = rem_in - trial;
               quo_in[chu_pkg::QUO_W - 1 - g * chu_pkg::DIV_STEPS - s] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (ld[g]) begin
            v_ff[g] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (ld[g]) begin
            rem_ff[g] <= rem_in;
            quo_ff[g] <= quo_in;
            den_ff[g] <= den_src;
            ctl_ff[g] <= ctl_src;
         end
      end
   end

   assign in_ready  = ld[0];
   assign out_valid = v_ff[NStg-1];
   assign quo       = quo_ff[NStg-1];
   assign out_ctl   = ctl_ff[NStg-1];

`include "circular_heading_utility_unit_defines.svh"

   `CHU_ASSERT_IMP(a_rem_below_den, v_ff[NStg-1] && !ctl_ff[NStg-1].bypass, rem_ff[NStg-1] < chu_pkg::PROD_W'(den_ff[NStg-1]), "divider remainder not below divisor")

endmodule

[rtl/core/chu_out.sv]
module chu_out (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [chu_pkg::QUO_W-1:0]    quo,
   input  chu_pkg::ctl_type             ctl,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [chu_pkg::UTIL_W-1:0]   utility,
   output logic                         on_starboard
);

   logic [chu_pkg::UTIL_W+1:0] acc;
   logic [chu_pkg::UTIL_W-1:0] util_in;
   logic                       v_ff;
   logic [chu_pkg::UTIL_W-1:0] util_ff;
   logic                       stbd_ff;
   logic                       ld;

   assign ld       = !v_ff || out_ready;
   assign in_ready = ld;

   // apply the truncated quotient with the sign of the slope, then clamp
   always_comb begin
      if (ctl.neg) begin
         acc = {2'b00, ctl.base} + {2'b00, quo};
      end else begin
         acc = {2'b00, ctl.base} - {2'b00, quo};
      end
      if (ctl.bypass) begin
         util_in = ctl.byp_val;
      end else if (acc[chu_pkg::UTIL_W+1]) begin
         util_in = '0;
      end else if (acc[chu_pkg::UTIL_W]) begin
         util_in = '1;
      end else begin
         util_in = acc[chu_pkg::UTIL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (ld) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         util_ff <= util_in;
         stbd_ff <= ctl.on_starboard;
      end
   end

   assign out_valid    = v_ff;
   assign utility      = util_ff;
   assign on_starboard = stbd_ff;

endmodule
